// ===== rtl/wsb_pkg.sv =====
// Shared types, widths and reset constants for the WS2812 bit serialiser.
`default_nettype none

package wsb_pkg;

   localparam int MAX_PIXELS_DEF = 64;
   localparam int BITS_PER_PIXEL = 24;

   localparam int COLOR_W    = 24;
   localparam int TICK_W     = 16;
   localparam int PIX_W      = 7;
   localparam int BIT_W      = 5;
   localparam int INDEX_W    = 6;
   localparam int LED_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TICK_W-1:0] ONE_HIGH_RST    = 16'd100;
   localparam logic [TICK_W-1:0] ZERO_HIGH_RST   = 16'd12;
   localparam logic [TICK_W-1:0] BIT_PERIOD_RST  = 16'd160;
   localparam logic [TICK_W-1:0] GAP_PERIOD_RST  = 16'h6000;
   localparam logic [TICK_W-1:0] START_SLOT_LEN  = 16'd16;
   localparam logic [LED_W-1:0]  LED_COUNT_RST   = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ONE_HIGH   = 3'd0,
      CSR_ZERO_HIGH  = 3'd1,
      CSR_BIT_PERIOD = 3'd2,
      CSR_GAP_PERIOD = 3'd3,
      CSR_LED_COUNT  = 3'd4
   } csr_index_type;

   typedef enum logic {
      FUNC_TICK  = 1'b0,
      FUNC_WRITE = 1'b1
   } func_type;

   typedef struct packed {
      logic [TICK_W-1:0] one_high;
      logic [TICK_W-1:0] zero_high;
      logic [TICK_W-1:0] bit_period;
      logic [TICK_W-1:0] gap_period;
      logic [LED_W-1:0]  led_count;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [BIT_W-1:0] bit_num;
   } pos_type;

   typedef struct packed {
      logic line_level;
      logic frame_start;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/wsb_ifs.sv =====
// Request, response and register-write channel interfaces.
`default_nettype none

interface wsb_req_if import wsb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               func;
   logic [INDEX_W-1:0] pixel_index;
   logic [COLOR_W-1:0] pixel_color;

   modport source (output valid, func, pixel_index, pixel_color, input ready);
   modport sink   (input valid, func, pixel_index, pixel_color, output ready);
endinterface

interface wsb_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic frame_start;

   modport source (output valid, line_level, frame_start, input ready);
   modport sink   (input valid, line_level, frame_start, output ready);
endinterface

interface wsb_csr_if import wsb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/wsb_csr_regs.sv =====
// Configuration registers written over the register-write channel.
`default_nettype none

module wsb_csr_regs import wsb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   wsb_csr_if.sink       csr,
   output cfg_type       cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_ONE_HIGH:   cfg_in.one_high   = csr.data;
            CSR_ZERO_HIGH:  cfg_in.zero_high  = csr.data;
            CSR_BIT_PERIOD: cfg_in.bit_period = csr.data;
            CSR_GAP_PERIOD: cfg_in.gap_period = csr.data;
            CSR_LED_COUNT:  cfg_in.led_count  = csr.data[LED_W-1:0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high   <= ONE_HIGH_RST;
         cfg_ff.zero_high  <= ZERO_HIGH_RST;
         cfg_ff.bit_period <= BIT_PERIOD_RST;
         cfg_ff.gap_period <= GAP_PERIOD_RST;
         cfg_ff.led_count  <= LED_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wsb_pixel_store.sv =====
// Pixel colour store with per-entry valid bits, registered read and write bypass.
`default_nettype none

module wsb_pixel_store import wsb_pkg::*; #(
   parameter int MAX_PIXELS = MAX_PIXELS_DEF,
   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [INDEX_W-1:0] wr_index,
   input  logic [COLOR_W-1:0] wr_color,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [COLOR_W-1:0] rd_word,
   output logic [COLOR_W-1:0] pix0_word
);

   logic [COLOR_W-1:0]         store_ff [MAX_PIXELS];
   logic [MAX_PIXELS-1:0]      valid_ff;
   logic [MAX_PIXELS-1:0]      valid_in;
   logic [COLOR_W-1:0]         rd_data_ff;
   logic                       rd_valid_ff;
   logic                       hit_ff;
   logic                       hit_in;
   logic [COLOR_W-1:0]         hit_data_ff;
   logic [COLOR_W-1:0]         pix0_ff;
   logic [COLOR_W-1:0]         pix0_in;
   logic [INDEX_W+ADDR_W-1:0]  wr_wide;
   logic [ADDR_W-1:0]          wr_addr;
   logic                       wr_ok;

   always_comb begin
      wr_wide  = {{ADDR_W{1'b0}}, wr_index};
      wr_addr  = wr_wide[ADDR_W-1:0];
      wr_ok    = wr_en && (32'(wr_index) < 32'(MAX_PIXELS));
      valid_in = valid_ff;
      if (wr_ok) begin
         valid_in[wr_addr] = 1'b1;
      end
      pix0_in = (wr_ok && wr_index == '0) ? wr_color : pix0_ff;
      hit_in  = wr_ok && (wr_addr == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         store_ff[wr_addr] <= wr_color;
      end
      rd_data_ff  <= store_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      hit_data_ff <= wr_color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pix0_ff  <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pix0_ff  <= pix0_in;
         hit_ff   <= hit_in;
      end
   end

   assign rd_word   = hit_ff ? hit_data_ff : (rd_valid_ff ? rd_data_ff : '0);
   assign pix0_word = pix0_ff;

endmodule

`default_nettype wire

// ===== rtl/wsb_slot_timer.sv =====
// Slot counter, bit and pixel sequencing, and line level generation.
`default_nettype none

module wsb_slot_timer import wsb_pkg::*; #(
   parameter int MAX_PIXELS = MAX_PIXELS_DEF,
   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick_en,
   input  cfg_type            cfg,
   input  logic [COLOR_W-1:0] fetch_word,
   input  logic [COLOR_W-1:0] pix0_word,
   output logic [ADDR_W-1:0]  fetch_addr,
   output result_type         result
);

   logic [TICK_W-1:0] slot_tick_ff,   slot_tick_in;
   logic [TICK_W-1:0] slot_length_ff, slot_length_in;
   logic [TICK_W-1:0] slot_high_ff,   slot_high_in;
   pos_type           pos_ff,         pos_in;
   logic              next_bit_ff,    next_bit_in;
   logic              first_slot_ff,  first_slot_in;

   logic                     slot_end;
   logic                     data_slot;
   pos_type                  end_pos;
   logic [COLOR_W-1:0]       end_word;
   pos_type                  fetch_pos;
   logic [PIX_W+ADDR_W-1:0]  fetch_wide;

   function automatic pos_type pos_advance(input pos_type p);
      logic [BIT_W-1:0] b;
      pos_type          r;
      b = p.bit_num + 1'b1;
      if ({1'b0, b} == (BIT_W+1)'(BITS_PER_PIXEL)) begin
         r.pixel   = p.pixel + 1'b1;
         r.bit_num = '0;
      end else begin
         r.pixel   = p.pixel;
         r.bit_num = b;
      end
      return r;
   endfunction

   function automatic logic sample_bit(input pos_type p, input logic [COLOR_W-1:0] word);
      logic [BIT_W:0] idx;
      logic           bit_val;
      idx = (BIT_W+1)'(BITS_PER_PIXEL - 1) - {1'b0, p.bit_num};
      if (32'(p.pixel) >= 32'(MAX_PIXELS) || 32'(p.bit_num) >= 32'(BITS_PER_PIXEL) ||
          idx >= (BIT_W+1)'(COLOR_W)) begin
         bit_val = 1'b0;
      end else begin
         bit_val = word[idx[BIT_W-1:0]];
      end
      return bit_val;
   endfunction

   always_comb begin
      result.line_level  = slot_tick_ff < slot_high_ff;
      result.frame_start = first_slot_ff && (slot_tick_ff == '0);

      slot_end  = slot_tick_ff >= slot_length_ff;
      data_slot = pos_ff.pixel < cfg.led_count;
      end_pos   = data_slot ? pos_advance(pos_ff) : '0;
      end_word  = data_slot ? fetch_word : pix0_word;

      slot_tick_in   = slot_tick_ff;
      slot_length_in = slot_length_ff;
      slot_high_in   = slot_high_ff;
      pos_in         = pos_ff;
      next_bit_in    = next_bit_ff;
      first_slot_in  = first_slot_ff;

      if (tick_en) begin
         if (slot_end) begin
            slot_tick_in = '0;
            pos_in       = end_pos;
            next_bit_in  = sample_bit(end_pos, end_word);
            if (data_slot) begin
               slot_length_in = cfg.bit_period;
               slot_high_in   = next_bit_ff ? cfg.one_high : cfg.zero_high;
               first_slot_in  = (pos_ff == '0);
            end else begin
               slot_length_in = cfg.gap_period;
               slot_high_in   = '0;
               first_slot_in  = 1'b0;
            end
         end else begin
            slot_tick_in = slot_tick_ff + 1'b1;
         end
      end

      fetch_pos  = pos_advance(pos_in);
      fetch_wide = {{ADDR_W{1'b0}}, fetch_pos.pixel};
      fetch_addr = fetch_wide[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_tick_ff   <= '0;
         slot_length_ff <= START_SLOT_LEN;
         slot_high_ff   <= '0;
         pos_ff         <= '0;
         next_bit_ff    <= 1'b0;
         first_slot_ff  <= 1'b0;
      end else begin
         slot_tick_ff   <= slot_tick_in;
         slot_length_ff <= slot_length_in;
         slot_high_ff   <= slot_high_in;
         pos_ff         <= pos_in;
         next_bit_ff    <= next_bit_in;
         first_slot_ff  <= first_slot_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ws2812_bit_serializer.sv =====
// Top level of the WS2812 bit serialiser: channels, result register and checks.
//
//   channel  | modport | payload                              | meaning
//   req_bus  | sink    | func, pixel_index, pixel_color       | tick or pixel write
//   rsp_bus  | source  | line_level, frame_start              | one per tick request
//   csr_bus  | sink    | index, data                          | register write
//
// One request per cycle while no stalled result is held; a tick's result appears in the
// result register the cycle after acceptance, a pixel write gives none.
// The store read is registered and addressed one slot ahead, so the word for
// the next bit is ready when the current slot ends.
// Synchronous reset clears the store valid bits, sequencer and result valid flag.
// A stalled result blocks new requests only while rsp_bus.ready is low.
`default_nettype none

module ws2812_bit_serializer import wsb_pkg::*; #(
   parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   wsb_req_if.sink     req_bus,
   wsb_rsp_if.source   rsp_bus,
   wsb_csr_if.sink     csr_bus
);

   localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

   cfg_type            cfg;
   logic               req_ready;
   logic               req_take;
   logic               tick_en;
   logic               wr_en;
   logic [ADDR_W-1:0]  fetch_addr;
   logic [COLOR_W-1:0] fetch_word;
   logic [COLOR_W-1:0] pix0_word;
   result_type         result;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff,  rsp_data_in;

   assign req_ready     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = req_ready;
   assign req_take      = req_bus.valid && req_ready;
   assign tick_en       = req_take && (func_type'(req_bus.func) == FUNC_TICK);
   assign wr_en         = req_take && (func_type'(req_bus.func) == FUNC_WRITE);

   wsb_csr_regs u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   wsb_pixel_store #(.MAX_PIXELS(MAX_PIXELS)) u_pixel_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_index  (req_bus.pixel_index),
      .wr_color  (req_bus.pixel_color),
      .rd_addr   (fetch_addr),
      .rd_word   (fetch_word),
      .pix0_word (pix0_word)
   );

   wsb_slot_timer #(.MAX_PIXELS(MAX_PIXELS)) u_slot_timer (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (tick_en),
      .cfg        (cfg),
      .fetch_word (fetch_word),
      .pix0_word  (pix0_word),
      .fetch_addr (fetch_addr),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (tick_en) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.line_level  = rsp_data_ff.line_level;
   assign rsp_bus.frame_start = rsp_data_ff.frame_start;

   a_tick_gives_result: assert property (@(posedge clock) disable iff (reset)
      tick_en |=> rsp_valid_ff)
      else $error("tick request left no result");

   a_write_gives_none: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (rsp_bus.ready || !rsp_valid_ff)) |=> !rsp_valid_ff)
      else $error("pixel write produced a result");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed");

endmodule

`default_nettype wire
